// File: hdl/assert_macros.svh
// Assertion macros shared by the tokenizer modules.
// Self-contained; taken in by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// A condition in one cycle that forces a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/exptok_pkg.sv
// Types, codes and the character classifier of the expression tokenizer.
// No dependencies; used by the tokenizer modules and the testbench.
package exptok_pkg;

    // Token kinds as they leave the block; SPACE is only an internal class.
    typedef enum logic [2:0] {
        KIND_NAME   = 3'd0,
        KIND_NUMBER = 3'd1,
        KIND_OPER   = 3'd2,
        KIND_OPEN   = 3'd3,
        KIND_CLOSE  = 3'd4,
        KIND_EOF    = 3'd5,
        KIND_ERROR  = 3'd6,
        KIND_SPACE  = 3'd7
    } t_kind;

    // Request codes of the input channel.
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // Default depth of the result queue.
    localparam int QUEUE_DEPTH_DEF = 4;

    // One result beat.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic       first;
        logic       last;
        logic       step_last;
    } t_result;

    // Which of the two result slots the core fills this cycle.
    typedef struct packed {
        logic push0;
        logic push1;
    } t_push;

    // Sort a byte into its character class.
    function automatic t_kind classify(input logic [7:0] c);
        t_kind k;
        k = KIND_ERROR;
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
            k = KIND_NAME;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            k = KIND_NUMBER;
        end else if (c == 8'h2B || c == 8'h2A || c == 8'h2D || c == 8'h2F ||
                     c == 8'h21 || c == 8'h3D || c == 8'h3C || c == 8'h3E) begin
            k = KIND_OPER;
        end else if (c == 8'h28) begin
            k = KIND_OPEN;
        end else if (c == 8'h29) begin
            k = KIND_CLOSE;
        end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
            k = KIND_SPACE;
        end
        return k;
    endfunction

endpackage

// File: hdl/exptok_in_if.sv
// Input channel of the tokenizer: one text byte or end-of-input per beat.
// No dependencies.
interface exptok_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] in_char;

    modport source (output valid, output req_type, output in_char, input ready);
    modport sink   (input valid, input req_type, input in_char, output ready);
endinterface

// File: hdl/exptok_out_if.sv
// Output channel of the tokenizer: one token character per beat.
// No dependencies.
interface exptok_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] token_kind;
    logic [7:0] out_char;
    logic       token_first;
    logic       token_last;
    logic       step_last;

    modport source (output valid, output token_kind, output out_char,
                    output token_first, output token_last, output step_last,
                    input ready);
    modport sink   (input valid, input token_kind, input out_char,
                    input token_first, input token_last, input step_last,
                    output ready);
endinterface

// File: hdl/expression_tokenizer_top.sv
// A result beat passes the input register, then the result queue head, before
// it is offered. Throughput: one item per cycle while the queue has room for
// two beats; an item that gives two results takes two output beats, so the
// single output port sets the rate for such items.
// Reset: synchronous, active low; clears the held run, the halt after an
// error token and the result queue. Depends on exptok_pkg, the interfaces,
// exptok_core and exptok_queue.
module expression_tokenizer_top
    import exptok_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    exptok_in_if.sink    i_req_ch,
    exptok_out_if.source o_res_ch
);

    logic       r_in_valid, n_in_valid;
    logic       r_in_req;
    logic [7:0] r_in_char;
    logic       room;
    logic       go;
    logic       take;
    t_result    res0;
    t_result    res1;
    t_push      push;
    t_push      push_go;

    // The registered item is processed when the queue has room for two beats.
    assign go             = r_in_valid && room;
    assign i_req_ch.ready = !r_in_valid || go;
    assign take           = i_req_ch.valid && i_req_ch.ready;
    assign n_in_valid     = take || (r_in_valid && !go);

    assign push_go.push0 = go && push.push0;
    assign push_go.push1 = go && push.push1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_req  <= i_req_ch.req_type;
            r_in_char <= i_req_ch.in_char;
        end
    end

    exptok_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (go),
        .i_req_type (r_in_req),
        .i_char     (r_in_char),
        .o_res0     (res0),
        .o_res1     (res1),
        .o_push     (push)
    );

    exptok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_res0   (res0),
        .i_res1   (res1),
        .i_push   (push_go),
        .o_room   (room),
        .o_res_ch (o_res_ch)
    );

endmodule

// File: hdl/exptok_core.sv
// Tokenizer state and result logic: holds back one run character and
// forms up to two results per item. Depends on exptok_pkg and assert_macros.svh.
`include "assert_macros.svh"

module exptok_core
    import exptok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic       i_req_type,
    input  logic [7:0] i_char,
    output t_result    o_res0,
    output t_result    o_res1,
    output t_push      o_push
);

    logic       r_held_valid, n_held_valid;
    logic [7:0] r_held_char,  n_held_char;
    logic [1:0] r_held_kind,  n_held_kind;
    logic       r_held_first, n_held_first;
    logic       r_stopped,    n_stopped;

    t_kind   cls;
    logic    is_end;
    logic    cont;
    logic    single;
    t_result held_res;
    t_result single_res;

    // Classify the byte and decide whether the held run goes on.
    always_comb begin
        cls    = classify(i_char);
        is_end = (i_req_type == REQ_END);
        cont   = r_held_valid && !is_end && (cls == t_kind'({1'b0, r_held_kind}));
        single = is_end || cls == KIND_OPEN || cls == KIND_CLOSE || cls == KIND_ERROR;
    end

    // The held character and the single-character token, if any.
    always_comb begin
        held_res.kind      = t_kind'({1'b0, r_held_kind});
        held_res.ch        = r_held_char;
        held_res.first     = r_held_first;
        held_res.last      = !cont;
        held_res.step_last = !single;

        single_res.kind      = is_end ? KIND_EOF : cls;
        single_res.ch        = is_end ? 8'h00 : i_char;
        single_res.first     = 1'b1;
        single_res.last      = 1'b1;
        single_res.step_last = 1'b1;
    end

    // Place the results: the held character always goes first.
    always_comb begin
        o_push.push0 = 1'b0;
        o_push.push1 = 1'b0;
        o_res0       = held_res;
        o_res1       = single_res;
        if (!r_stopped) begin
            if (r_held_valid) begin
                o_push.push0 = 1'b1;
                o_push.push1 = single;
            end else begin
                o_res0       = single_res;
                o_push.push0 = single;
            end
        end
    end

    // Next state.
    always_comb begin
        n_held_valid = r_held_valid;
        n_held_char  = r_held_char;
        n_held_kind  = r_held_kind;
        n_held_first = r_held_first;
        n_stopped    = r_stopped;
        if (!r_stopped) begin
            if (is_end) begin
                n_held_valid = 1'b0;
            end else if (cont) begin
                n_held_char  = i_char;
                n_held_first = 1'b0;
            end else begin
                n_held_valid = (cls == KIND_NAME || cls == KIND_NUMBER || cls == KIND_OPER);
                if (n_held_valid) begin
                    n_held_char  = i_char;
                    n_held_kind  = cls[1:0];
                    n_held_first = 1'b1;
                end
                if (cls == KIND_ERROR) begin
                    n_stopped = 1'b1;
                end
            end
        end
    end

    // State registers advance only when an item is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_char  <= 8'h00;
            r_held_kind  <= 2'd0;
            r_held_first <= 1'b0;
            r_stopped    <= 1'b0;
        end else if (i_go) begin
            r_held_valid <= n_held_valid;
            r_held_char  <= n_held_char;
            r_held_kind  <= n_held_kind;
            r_held_first <= n_held_first;
            r_stopped    <= n_stopped;
        end
    end

    // Once stopped, only reset clears the halt.
    `ASSERT_NEXT(a_stop_sticky, i_clk, i_rst_n, r_stopped, r_stopped, "halt dropped")
    // A held run is always a name, number or operator.
    `ASSERT_ALWAYS(a_held_kind, i_clk, i_rst_n, !r_held_valid || r_held_kind != 2'd3, "bad kind")

endmodule

// File: hdl/exptok_queue.sv
// Result queue: takes up to two results a cycle; gives one beat a cycle on the
// output while ready. Depends on exptok_pkg, exptok_out_if, assert_macros.svh.
`include "assert_macros.svh"

module exptok_queue
    import exptok_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_result      i_res0,
    input  t_result      i_res1,
    input  t_push        i_push,
    output logic         o_room,
    exptok_out_if.source o_res_ch
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_result       r_q [DEPTH];
    t_result       n_q [DEPTH];
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] base0;
    logic [CW-1:0] base1;
    logic          pop;

    // Head entry drives the output channel.
    assign pop                  = o_res_ch.valid && o_res_ch.ready;
    assign o_res_ch.valid       = (r_cnt != '0);
    assign o_res_ch.token_kind  = r_q[0].kind;
    assign o_res_ch.out_char    = r_q[0].ch;
    assign o_res_ch.token_first = r_q[0].first;
    assign o_res_ch.token_last  = r_q[0].last;
    assign o_res_ch.step_last   = r_q[0].step_last;

    // Room for two new results, whatever the output does this cycle.
    assign o_room = (r_cnt <= CW'(DEPTH - 2));

    // Shift out the head, then append the new results behind the rest.
    always_comb begin
        n_q   = r_q;
        base0 = r_cnt - CW'(pop);
        base1 = base0 + CW'(1);
        if (pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
        end
        if (i_push.push0) begin
            n_q[base0[IW-1:0]] = i_res0;
        end
        if (i_push.push1) begin
            n_q[base1[IW-1:0]] = i_res1;
        end
        n_cnt = base0 + CW'(i_push.push0) + CW'(i_push.push1);
    end

    // Entries carry no reset; the count says which are live.
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // The count never passes the depth.
    `ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(DEPTH), "result queue overflow")
    // A second result is only written together with a first.
    `ASSERT_ALWAYS(a_push_order, i_clk, i_rst_n, !i_push.push1 || i_push.push0, "second result without first")

endmodule

// File: tb/expression_tokenizer_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of expression_tokenizer_top: directed and random byte streams,
// checked beat by beat against a predictor of the tokenizer held in a scoreboard class.
// Depends on exptok_pkg, exptok_in_if, exptok_out_if and the tokenizer RTL.
module expression_tokenizer_top_tb;
    import exptok_pkg::*;

    localparam int ITEM_COUNT   = 800;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    // Predicts the token beats of the tokenizer and checks the beats that leave it.
    class token_checker;
        logic       held_valid;
        logic [7:0] held_char;
        t_kind      held_kind;
        logic       held_first;
        logic       stopped;
        t_result    pending_tokens[$];
        int         errors;
        int         reports;

        function new();
            held_valid = 1'b0;
            held_char  = 8'h00;
            held_kind  = KIND_NAME;
            held_first = 1'b0;
            stopped    = 1'b0;
            errors     = 0;
            reports    = 0;
        endfunction

        // Character class of a byte; whitespace has its own internal class.
        static function t_kind char_kind(input logic [7:0] c);
            t_kind k;
            case (c)
                "+", "*", "-", "/", "!", "=", "<", ">": k = KIND_OPER;
                "(": k = KIND_OPEN;
                ")": k = KIND_CLOSE;
                " ", 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: k = KIND_SPACE;
                default: begin
                    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
                        k = KIND_NAME;
                    end else if (c >= "0" && c <= "9") begin
                        k = KIND_NUMBER;
                    end else begin
                        k = KIND_ERROR;
                    end
                end
            endcase
            return k;
        endfunction

        function void add_token(input t_kind k, input logic [7:0] c,
                                input logic first, input logic last);
            t_result r;
            r.kind      = k;
            r.ch        = c;
            r.first     = first;
            r.last      = last;
            r.step_last = 1'b0;
            pending_tokens = {pending_tokens, r};
        endfunction

        // Works out the token beats that one accepted input beat causes.
        function void take_item(input logic req, input logic [7:0] c);
            int      q_size0;
            t_kind   cls;
            t_result r;
            q_size0 = pending_tokens.size();
            if (stopped) begin
                return;
            end
            if (req == REQ_END) begin
                // End of input flushes the held run, then closes the stream.
                if (held_valid) begin
                    add_token(held_kind, held_char, held_first, 1'b1);
                end
                held_valid = 1'b0;
                add_token(KIND_EOF, 8'h00, 1'b1, 1'b1);
            end else begin
                cls = char_kind(c);
                if (held_valid && cls == held_kind) begin
                    // The run goes on: release the held character, hold the new one.
                    add_token(held_kind, held_char, held_first, 1'b0);
                    held_char  = c;
                    held_first = 1'b0;
                end else begin
                    if (held_valid) begin
                        add_token(held_kind, held_char, held_first, 1'b1);
                    end
                    held_valid = 1'b0;
                    case (cls)
                        KIND_NAME, KIND_NUMBER, KIND_OPER: begin
                            held_valid = 1'b1;
                            held_char  = c;
                            held_kind  = cls;
                            held_first = 1'b1;
                        end
                        KIND_OPEN, KIND_CLOSE: begin
                            add_token(cls, c, 1'b1, 1'b1);
                        end
                        KIND_ERROR: begin
                            add_token(KIND_ERROR, c, 1'b1, 1'b1);
                            stopped = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // The last beat caused by this input carries step_last.
            if (pending_tokens.size() > q_size0) begin
                r = pending_tokens[$];
                r.step_last = 1'b1;
                pending_tokens[pending_tokens.size() - 1] = r;
            end
        endfunction

        // Compares one accepted token beat with the oldest prediction.
        function void check_token(input t_result got);
            t_result want;
            if (pending_tokens.size() == 0) begin
                errors++;
                if (reports < 40) begin
                    reports++;
                    $display({"%0t: token beat with none expected: expected none, ",
                              "got kind %0d char %02h first %0b last %0b step_last %0b"},
                             $time, got.kind, got.ch, got.first, got.last, got.step_last);
                end
                return;
            end
            want = pending_tokens.pop_front();
            if (got.kind !== want.kind || got.ch !== want.ch || got.first !== want.first ||
                got.last !== want.last || got.step_last !== want.step_last) begin
                errors++;
                if (reports < 40) begin
                    reports++;
                    $display({"%0t: token mismatch: expected kind %0d char %02h first %0b ",
                              "last %0b step_last %0b, got kind %0d char %02h first %0b ",
                              "last %0b step_last %0b"},
                             $time, want.kind, want.ch, want.first, want.last, want.step_last,
                             got.kind, got.ch, got.first, got.last, got.step_last);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic no_idle;
    int   items_sent;
    int   stall_cycles;

    token_checker tokens = new();

    exptok_in_if  req_if ();
    exptok_out_if res_if ();

    expression_tokenizer_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req_ch (req_if),
        .o_res_ch (res_if)
    );

    // Clock with a 10 ns period.
    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The result side stalls in about a quarter of the cycles, except in the calm stretch.
    initial begin
        res_if.ready = 1'b0;
    end
    always @(negedge i_clk) begin
        res_if.ready <= no_idle || ($urandom_range(0, 99) >= 26);
    end

    // Beat monitor and watchdog, sampled at the rising edge.
    always @(posedge i_clk) begin
        t_result beat;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                tokens.take_item(req_if.req_type, req_if.in_char);
            end
            if (res_if.valid && res_if.ready) begin
                beat.kind      = t_kind'(res_if.token_kind);
                beat.ch        = res_if.out_char;
                beat.first     = res_if.token_first;
                beat.last      = res_if.token_last;
                beat.step_last = res_if.step_last;
                tokens.check_token(beat);
            end
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("expression_tokenizer_top_tb: FAIL");
                $finish;
            end
        end
    end

    // Offers one input beat, with random idle cycles first, and waits for its acceptance.
    task automatic send_item(input logic req, input logic [7:0] c);
        while (!no_idle && $urandom_range(0, 99) < 26) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= req;
        req_if.in_char  <= c;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        items_sent++;
        no_idle <= (items_sent >= 300 && items_sent < 450);
    endtask

    task automatic send_byte(input logic [7:0] c);
        send_item(REQ_BYTE, c);
    endtask

    task automatic send_end(input logic [7:0] c);
        send_item(REQ_END, c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    // A random byte of the given class; parentheses for the bracket kinds.
    function automatic logic [7:0] pick_char(input t_kind k);
        string      ops;
        int         r;
        logic [7:0] c;
        ops = "+*-/!=<>";
        case (k)
            KIND_NAME: begin
                c = $urandom_range(0, 1) ? 8'("A" + $urandom_range(0, 25))
                                         : 8'("a" + $urandom_range(0, 25));
            end
            KIND_NUMBER: c = 8'("0" + $urandom_range(0, 9));
            KIND_OPER:   c = ops[$urandom_range(0, 7)];
            KIND_SPACE: begin
                r = $urandom_range(0, 5);
                c = (r == 5) ? 8'h20 : 8'(8'h09 + r);
            end
            default: c = $urandom_range(0, 1) ? "(" : ")";
        endcase
        return c;
    endfunction

    // A run of one class, mostly short and now and then long.
    task automatic send_run(input t_kind k);
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        repeat (len) begin
            send_byte(pick_char(k));
        end
    endtask

    // Stimulus: reset, directed streams, random streams, then the error halt.
    initial begin
        int         pick;
        logic [7:0] c;
        i_rst_n         = 1'b0;
        no_idle         = 1'b0;
        items_sent      = 0;
        stall_cycles    = 0;
        req_if.valid    = 1'b0;
        req_if.req_type = REQ_BYTE;
        req_if.in_char  = 8'h00;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: an empty stream, runs of every held class ended by another class,
        // a bracket, whitespace or end, every operator, both parentheses, every whitespace byte, and two ends.
        send_end(8'hFF);
        send_text("Az09+*-/!=<>(a");
        send_byte(" ");
        send_byte(")");
        send_byte(8'h09);
        send_byte(8'h0A);
        send_byte(8'h0B);
        send_byte(8'h0C);
        send_byte(8'h0D);
        send_byte("Z");
        send_end(8'h00);
        send_end(8'h80);

        // Random: well-formed streams with random content, plus stray recognised bytes.
        while (items_sent < ITEM_COUNT) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                send_run(t_kind'($urandom_range(0, 2)));
            end else if (pick < 62) begin
                send_byte(pick_char(KIND_OPEN));
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 2)) send_byte(pick_char(KIND_SPACE));
            end else if (pick < 88) begin
                send_end(8'($urandom_range(0, 255)));
            end else begin
                do begin
                    c = 8'($urandom_range(0, 255));
                end while (token_checker::char_kind(c) == KIND_ERROR);
                send_byte(c);
            end
        end

        // An unrecognised byte flushes the held run and halts the block for good.
        send_byte(pick_char(KIND_NAME));
        do begin
            c = 8'($urandom_range(0, 255));
        end while (token_checker::char_kind(c) != KIND_ERROR);
        send_byte(c);
        send_byte("x");
        send_byte("(");
        send_end(8'($urandom_range(0, 255)));
        req_if.valid <= 1'b0;

        // Drain the outstanding tokens, then give stray beats time to show.
        while (tokens.pending_tokens.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tokens.errors == 0 && tokens.pending_tokens.size() == 0) begin
            $display("expression_tokenizer_top_tb: PASS");
        end else begin
            $display("expression_tokenizer_top_tb: FAIL");
        end
        $finish;
    end

endmodule
